// ===== rtl/core/eilc_pkg.sv =====
package eilc_pkg;

  localparam int unsigned NumLines = 16;
  localparam int unsigned NumIrq   = 7;

  // line ranges: lines 0 to SingleHi get one output each, groups A and B share one output each
  localparam int unsigned SingleHi = 4;
  localparam int unsigned GrpALo   = 5;
  localparam int unsigned GrpAHi   = 9;
  localparam int unsigned GrpBLo   = 10;
  localparam int unsigned GrpBHi   = 15;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] REG_INT_EN  = 3'd0;
  localparam logic [2:0] REG_EVT_EN  = 3'd1;
  localparam logic [2:0] REG_RISE_EN = 3'd2;
  localparam logic [2:0] REG_FALL_EN = 3'd3;
  localparam logic [2:0] REG_SWTRIG  = 3'd4;
  localparam logic [2:0] REG_PENDING = 3'd5;

  typedef logic [NumLines-1:0] lines_t;

  typedef struct packed {
    lines_t            read_data;
    logic [NumIrq-1:0] irq_lines;
    lines_t            event_pulses;
    lines_t            flagged_lines;
  } result_t;

endpackage

// ===== rtl/core/eilc_core.sv =====
module eilc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           command_i,
  input  logic [2:0]           reg_select_i,
  input  eilc_pkg::lines_t     write_data_i,
  input  eilc_pkg::lines_t     pin_levels_i,
  output eilc_pkg::result_t    result_o
);

  eilc_pkg::lines_t int_en_q,  int_en_d;
  eilc_pkg::lines_t evt_en_q,  evt_en_d;
  eilc_pkg::lines_t rise_en_q, rise_en_d;
  eilc_pkg::lines_t fall_en_q, fall_en_d;
  eilc_pkg::lines_t swtrig_q,  swtrig_d;
  eilc_pkg::lines_t pending_q, pending_d;
  eilc_pkg::lines_t prev_q,    prev_d;

  eilc_pkg::lines_t hit;
  eilc_pkg::lines_t new_trig;
  eilc_pkg::lines_t events;
  eilc_pkg::lines_t rdata;
  eilc_pkg::lines_t flagged;

  always_comb begin
    int_en_d  = int_en_q;
    evt_en_d  = evt_en_q;
    rise_en_d = rise_en_q;
    fall_en_d = fall_en_q;
    swtrig_d  = swtrig_q;
    pending_d = pending_q;
    prev_d    = prev_q;
    events    = '0;
    rdata     = '0;
    hit       = (pin_levels_i & ~prev_q & rise_en_q) | (~pin_levels_i & prev_q & fall_en_q);
    new_trig  = write_data_i & ~swtrig_q;

    case (command_i)
      eilc_pkg::CMD_TICK: begin
        pending_d = pending_q | hit;
        events    = hit & evt_en_q;
        prev_d    = pin_levels_i;
      end
      eilc_pkg::CMD_WRITE: begin
        case (reg_select_i)
          eilc_pkg::REG_INT_EN:  int_en_d  = write_data_i;
          eilc_pkg::REG_EVT_EN:  evt_en_d  = write_data_i;
          eilc_pkg::REG_RISE_EN: rise_en_d = write_data_i;
          eilc_pkg::REG_FALL_EN: fall_en_d = write_data_i;
          eilc_pkg::REG_SWTRIG: begin
            // only bits going 0 to 1 fire
            pending_d = pending_q | new_trig;
            events    = new_trig & evt_en_q;
            swtrig_d  = write_data_i;
          end
          eilc_pkg::REG_PENDING: begin
            // write one to clear, trigger bit goes with it
            pending_d = pending_q & ~write_data_i;
            swtrig_d  = swtrig_q & ~write_data_i;
          end
          default: ;
        endcase
      end
      eilc_pkg::CMD_READ: begin
        case (reg_select_i)
          eilc_pkg::REG_INT_EN:  rdata = int_en_q;
          eilc_pkg::REG_EVT_EN:  rdata = evt_en_q;
          eilc_pkg::REG_RISE_EN: rdata = rise_en_q;
          eilc_pkg::REG_FALL_EN: rdata = fall_en_q;
          eilc_pkg::REG_SWTRIG:  rdata = swtrig_q;
          eilc_pkg::REG_PENDING: rdata = pending_q;
          default:               rdata = '0;
        endcase
      end
      default: ;
    endcase

    flagged = pending_d & int_en_d;
  end

  assign result_o.read_data     = rdata;
  assign result_o.event_pulses  = events;
  assign result_o.flagged_lines = flagged;
  assign result_o.irq_lines     = {
    |flagged[eilc_pkg::GrpBHi:eilc_pkg::GrpBLo],
    |flagged[eilc_pkg::GrpAHi:eilc_pkg::GrpALo],
    flagged[eilc_pkg::SingleHi:0]
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_en_q  <= '0;
      evt_en_q  <= '0;
      rise_en_q <= '0;
      fall_en_q <= '0;
      swtrig_q  <= '0;
      pending_q <= '0;
      prev_q    <= '0;
    end else if (accept_i) begin
      int_en_q  <= int_en_d;
      evt_en_q  <= evt_en_d;
      rise_en_q <= rise_en_d;
      fall_en_q <= fall_en_d;
      swtrig_q  <= swtrig_d;
      pending_q <= pending_d;
      prev_q    <= prev_d;
    end
  end

endmodule

// ===== rtl/core/eilc_out_reg.sv =====
module eilc_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  eilc_pkg::result_t  result_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               free_o,
  output eilc_pkg::result_t  result_o
);

  logic              valid_q;
  eilc_pkg::result_t data_q;

  // slot frees up in the same cycle the held item is taken
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== rtl/core/external_interrupt_line_controller.sv =====
// result: registered, valid in the cycle after the item is accepted
// throughput: one item per cycle, back to back, while out_ready_i is high
// in_ready_o stays high while the single result register is empty or being drained
// reset: asynchronous, active low; all line registers, pending and last levels clear
// to zero, result register empty, so lines high on the first tick count as rising
module external_interrupt_line_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  reg_select_i,
  input  logic [15:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic [6:0]  irq_lines_o,
  output logic [15:0] event_pulses_o,
  output logic [15:0] flagged_lines_o
);

  logic              accept;
  logic              free;
  eilc_pkg::result_t result_d;
  eilc_pkg::result_t result_q;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  eilc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .reg_select_i (reg_select_i),
    .write_data_i (write_data_i),
    .pin_levels_i (pin_levels_i),
    .result_o     (result_d)
  );

  eilc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (result_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (free),
    .result_o    (result_q)
  );

  assign read_data_o     = result_q.read_data;
  assign irq_lines_o     = result_q.irq_lines;
  assign event_pulses_o  = result_q.event_pulses;
  assign flagged_lines_o = result_q.flagged_lines;

endmodule

// ===== rtl/core/eilc_checker.sv =====
module eilc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] read_data_o,
  input logic [6:0]  irq_lines_o,
  input logic [15:0] event_pulses_o,
  input logic [15:0] flagged_lines_o
);

  // an accepted item always shows up as a result on the next cycle
  a_item_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // only reads return register contents
  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i != eilc_pkg::CMD_READ |=> read_data_o == '0)
    else $error("read data on a non-read item");

  // reads never pulse events
  a_read_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == eilc_pkg::CMD_READ |=> event_pulses_o == '0)
    else $error("event pulse on a read");

  // interrupt outputs are the reduction of the flagged lines
  a_irq_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> irq_lines_o == {|flagged_lines_o[15:10], |flagged_lines_o[9:5],
                                    flagged_lines_o[4:0]})
    else $error("irq lines disagree with flagged lines");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flagged_lines_o))
    else $error("stalled result changed");

endmodule

bind external_interrupt_line_controller eilc_checker u_eilc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_data_o     (read_data_o),
  .irq_lines_o     (irq_lines_o),
  .event_pulses_o  (event_pulses_o),
  .flagged_lines_o (flagged_lines_o)
);

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // command three and selects above five are not named in the package
  localparam logic [1:0] CmdNop        = 2'd3;
  localparam logic [2:0] RegUnmappedLo = 3'd6;
  localparam logic [2:0] RegUnmappedHi = 3'd7;

  localparam int unsigned NumRandomItems = 1600;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned CycleLimit     = 400000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i      = eilc_pkg::CMD_TICK;
  logic [2:0]  reg_select_i   = eilc_pkg::REG_INT_EN;
  logic [15:0] write_data_i   = '0;
  logic [15:0] pin_levels_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] read_data_o;
  logic [6:0]  irq_lines_o;
  logic [15:0] event_pulses_o;
  logic [15:0] flagged_lines_o;

  external_interrupt_line_controller u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .reg_select_i   (reg_select_i),
    .write_data_i   (write_data_i),
    .pin_levels_i   (pin_levels_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .irq_lines_o    (irq_lines_o),
    .event_pulses_o (event_pulses_o),
    .flagged_lines_o(flagged_lines_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted controller state
  eilc_pkg::lines_t int_en_q, evt_en_q, rise_en_q, fall_en_q;
  eilc_pkg::lines_t swtrig_q, pending_q, last_pins_q;

  eilc_pkg::result_t expected_status_q[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;

  // sender burst control
  int unsigned burst_left  = 0;
  bit          idle_enable = 1'b1;

  // receiver stall control
  int unsigned rx_cycle     = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_request = 0;
  logic        ready_next;

  eilc_pkg::result_t got_status, want_status;

  function automatic eilc_pkg::result_t predict_status(input logic [1:0] cmd,
                                                       input logic [2:0] sel,
                                                       input eilc_pkg::lines_t data,
                                                       input eilc_pkg::lines_t pins);
    eilc_pkg::lines_t  hit;
    eilc_pkg::lines_t  fresh;
    eilc_pkg::lines_t  flagged;
    eilc_pkg::result_t r;
    r = '0;
    case (cmd)
      eilc_pkg::CMD_TICK: begin
        hit = (pins & ~last_pins_q & rise_en_q) | (~pins & last_pins_q & fall_en_q);
        pending_q = pending_q | hit;
        r.event_pulses = hit & evt_en_q;
        last_pins_q = pins;
      end
      eilc_pkg::CMD_WRITE: begin
        case (sel)
          eilc_pkg::REG_INT_EN:  int_en_q  = data;
          eilc_pkg::REG_EVT_EN:  evt_en_q  = data;
          eilc_pkg::REG_RISE_EN: rise_en_q = data;
          eilc_pkg::REG_FALL_EN: fall_en_q = data;
          eilc_pkg::REG_SWTRIG: begin
            fresh = data & ~swtrig_q;
            pending_q = pending_q | fresh;
            r.event_pulses = fresh & evt_en_q;
            swtrig_q = data;
          end
          eilc_pkg::REG_PENDING: begin
            pending_q = pending_q & ~data;
            swtrig_q  = swtrig_q & ~data;
          end
          default: ;
        endcase
      end
      eilc_pkg::CMD_READ: begin
        case (sel)
          eilc_pkg::REG_INT_EN:  r.read_data = int_en_q;
          eilc_pkg::REG_EVT_EN:  r.read_data = evt_en_q;
          eilc_pkg::REG_RISE_EN: r.read_data = rise_en_q;
          eilc_pkg::REG_FALL_EN: r.read_data = fall_en_q;
          eilc_pkg::REG_SWTRIG:  r.read_data = swtrig_q;
          eilc_pkg::REG_PENDING: r.read_data = pending_q;
          default:               r.read_data = '0;
        endcase
      end
      default: ;
    endcase
    flagged = pending_q & int_en_q;
    r.flagged_lines = flagged;
    r.irq_lines = {|flagged[eilc_pkg::GrpBHi:eilc_pkg::GrpBLo],
                   |flagged[eilc_pkg::GrpAHi:eilc_pkg::GrpALo],
                   flagged[eilc_pkg::SingleHi:0]};
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycle_count);
    mismatch_count++;
  endtask

  // offers one item and records its prediction once accepted
  task automatic issue_item(input logic [1:0] cmd, input logic [2:0] sel,
                            input eilc_pkg::lines_t data, input eilc_pkg::lines_t pins);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (idle_enable) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    reg_select_i <= sel;
    write_data_i <= data;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (!in_ready_o);
    expected_status_q.push_back(predict_status(cmd, sel, data, pins));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_status_q.size() != 0);
  endtask

  function automatic eilc_pkg::lines_t rand_lines();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return eilc_pkg::lines_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic issue_random_item();
    int unsigned kind;
    logic [2:0]  sel;
    kind = $urandom_range(0, 99);
    sel  = 3'($urandom_range(0, 5));
    if (kind < 40) begin
      issue_item(eilc_pkg::CMD_TICK, 3'($urandom_range(0, 7)), rand_lines(), rand_lines());
    end else if (kind < 75) begin
      if ($urandom_range(0, 19) == 0) sel = 3'($urandom_range(RegUnmappedLo, RegUnmappedHi));
      issue_item(eilc_pkg::CMD_WRITE, sel, rand_lines(), rand_lines());
    end else if (kind < 95) begin
      issue_item(eilc_pkg::CMD_READ, 3'($urandom_range(0, 7)), rand_lines(), rand_lines());
    end else begin
      issue_item(CmdNop, 3'($urandom_range(0, 7)), rand_lines(), rand_lines());
    end
  endtask

  task automatic test_reset_state();
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_INT_EN, '0, '0);
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_PENDING, '1, '1);
    issue_item(eilc_pkg::CMD_WRITE, RegUnmappedLo, '1, '0);
    issue_item(eilc_pkg::CMD_READ, RegUnmappedHi, '0, '0);
    issue_item(CmdNop, eilc_pkg::REG_PENDING, '1, '1);
    wait_drained();
  endtask

  task automatic test_edge_detection();
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_RISE_EN, 16'hffff, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_INT_EN, 16'hffff, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_EVT_EN, 16'hf0f0, '0);
    // first tick after reset: every line high is a rising edge
    issue_item(eilc_pkg::CMD_TICK, '0, '0, 16'hffff);
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_PENDING, '0, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_PENDING, 16'hffff, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_FALL_EN, 16'hffff, '0);
    issue_item(eilc_pkg::CMD_TICK, '0, '0, 16'h0000);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_RISE_EN, 16'h0000, '0);
    issue_item(eilc_pkg::CMD_TICK, '0, '0, 16'h8421);
    wait_drained();
  endtask

  task automatic test_soft_trigger();
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_PENDING, 16'hffff, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_SWTRIG, 16'haaaa, '0);
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_SWTRIG, '0, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_PENDING, 16'h00ff, '0);
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_SWTRIG, '0, '0);
    // pending still sets with interrupts masked
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_INT_EN, 16'h0000, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_SWTRIG, 16'hffff, '0);
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_PENDING, '0, '0);
    issue_item(eilc_pkg::CMD_WRITE, eilc_pkg::REG_INT_EN, 16'h0421, '0);
    issue_item(eilc_pkg::CMD_READ, eilc_pkg::REG_FALL_EN, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int unsigned i = 0; i < NumRandomItems; i++) begin
      if (i % 200 == 0) idle_enable = (i % 400 != 0);
      issue_random_item();
    end
    idle_enable = 1'b1;
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    idle_enable  = 1'b0;
    hold_request = HoldCycles;
    repeat (40) issue_random_item();
    idle_enable = 1'b1;
    wait_drained();
  endtask

  task automatic test_pause_until_empty();
    repeat (3) begin
      repeat (12) issue_random_item();
      wait_drained();
    end
  endtask

  // receiver: long hold on request, otherwise a rotating stall pattern
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left == 0 && hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       ready_next = 1'b1;
        1:       ready_next = 1'($urandom_range(0, 1));
        2:       ready_next = ($urandom_range(0, 3) != 0);
        default: ready_next = (rx_cycle % 8 != 0);
      endcase
    end
    out_ready_i <= ready_next;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_status = '{read_data_o, irq_lines_o, event_pulses_o, flagged_lines_o};
      if (expected_status_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, got_status.flagged_lines);
      end else begin
        want_status = expected_status_q.pop_front();
        if (got_status.read_data != want_status.read_data)
          flag_mismatch("read_data", want_status.read_data, got_status.read_data);
        if (got_status.irq_lines != want_status.irq_lines)
          flag_mismatch("irq_lines", 16'(want_status.irq_lines), 16'(got_status.irq_lines));
        if (got_status.event_pulses != want_status.event_pulses)
          flag_mismatch("event_pulses", want_status.event_pulses, got_status.event_pulses);
        if (got_status.flagged_lines != want_status.flagged_lines)
          flag_mismatch("flagged_lines", want_status.flagged_lines, got_status.flagged_lines);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int_en_q    = '0;
    evt_en_q    = '0;
    rise_en_q   = '0;
    fall_en_q   = '0;
    swtrig_q    = '0;
    pending_q   = '0;
    last_pins_q = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_edge_detection();
    test_soft_trigger();
    test_random_traffic();
    test_output_backpressure();
    test_pause_until_empty();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
